// ===== src/gsdc_pkg.sv =====
// gsdc_pkg: shared constants, cell codes, types and state encoding
// used by the spreading sequencer and the top level
package gsdc_pkg;

	localparam int MAX_SIDE = 128;
	localparam int SIDE_W   = $clog2(MAX_SIDE);
	localparam int N_W      = SIDE_W + 1;
	localparam int ADDR_W   = 2 * SIDE_W;
	localparam int CNT_W    = 15;
	localparam int GEN_W    = 16;
	localparam int GSZ_W    = 8;
	localparam int K_W      = 3;

	localparam logic [1:0] KIND_EMPTY   = 2'd0;
	localparam logic [1:0] KIND_MARKED  = 2'd1;
	localparam logic [1:0] KIND_BLOCKED = 2'd2;
	// empty cell marked during the current generation, not yet a source
	localparam logic [1:0] KIND_FRESH   = 2'd3;

	localparam logic REG_GRID_SIZE = 1'b0;
	localparam logic REG_DAY_COUNT = 1'b1;

	localparam logic [K_W-1:0] NB_SELF  = 3'd0;
	localparam logic [K_W-1:0] NB_UP    = 3'd1;
	localparam logic [K_W-1:0] NB_DOWN  = 3'd2;
	localparam logic [K_W-1:0] NB_LEFT  = 3'd3;
	localparam logic [K_W-1:0] NB_RIGHT = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_A_ISSUE,
		S_A_WAIT,
		S_B_ISSUE,
		S_B_WAIT,
		S_C_ISSUE,
		S_C_WAIT,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [1:0]        wr_data;
	} mem_req_t;

endpackage

// ===== src/grid_spread_dilation_count_top.sv =====
// Cells load one per cycle in row-major order while the block is idle. On the
// transfer that carries last_cell the input stalls while the grid of side n is
// swept through a single-port-read cell ram: each spreading generation reads
// every cell and, for an empty cell, its neighbors in the grid until a marked
// one is found (one ram read per cell and neighbor), plus a commit sweep;
// sweeping ends early once a generation marks nothing. A final count sweep
// then produces marked_count, and the next cell is taken once that result has
// been transferred. No clearing pass is needed after reset.
// top level: configuration, load counter, output register; uses gsdc_pkg,
// gsdc_ram and gsdc_seq
module grid_spread_dilation_count_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      cell_kind,
	input  logic                            last_cell,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [gsdc_pkg::CNT_W-1:0]      marked_count,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [gsdc_pkg::GEN_W-1:0]      cfg_data
);

	logic [gsdc_pkg::GSZ_W-1:0]  grid_size_q;
	logic [gsdc_pkg::GEN_W-1:0]  day_count_q;
	logic [gsdc_pkg::SIDE_W-1:0] load_row_q, load_col_q;
	logic [gsdc_pkg::ADDR_W-1:0] load_addr_q;
	logic                        load_full_q;
	logic                        busy_q, out_valid_q;
	logic [gsdc_pkg::CNT_W-1:0]  count_q;

	logic [gsdc_pkg::N_W-1:0]    side;
	logic [gsdc_pkg::GEN_W-1:0]  gens;
	logic                        in_xfer, start, done;
	logic                        load_last_col, load_last_row;
	logic [1:0]                  load_kind;
	gsdc_pkg::mem_req_t          seq_req;
	logic [1:0]                  rd_data;
	logic [gsdc_pkg::CNT_W-1:0]  seq_count;
	logic                        ram_wr_en;
	logic [gsdc_pkg::ADDR_W-1:0] ram_wr_addr;
	logic [1:0]                  ram_wr_data;

	always_comb begin
		if (grid_size_q == '0) begin
			side = gsdc_pkg::N_W'(1);
		end else if (int'(grid_size_q) > gsdc_pkg::MAX_SIDE) begin
			side = gsdc_pkg::N_W'(gsdc_pkg::MAX_SIDE);
		end else begin
			side = gsdc_pkg::N_W'(grid_size_q);
		end
	end

	assign gens      = (day_count_q == '0) ? '0 : day_count_q - gsdc_pkg::GEN_W'(1);
	assign cfg_ready = 1'b1;
	assign in_stall  = busy_q;
	assign in_xfer   = in_valid && !busy_q;
	assign start     = in_xfer && last_cell;

	assign load_last_col = ({1'b0, load_col_q} == side - gsdc_pkg::N_W'(1));
	assign load_last_row = ({1'b0, load_row_q} == side - gsdc_pkg::N_W'(1));
	// kind three behaves as blocked, store it so the fresh code stays free
	assign load_kind = (cell_kind == gsdc_pkg::KIND_FRESH) ? gsdc_pkg::KIND_BLOCKED : cell_kind;

	always_comb begin
		if (busy_q) begin
			ram_wr_en   = seq_req.wr_en;
			ram_wr_addr = seq_req.wr_addr;
			ram_wr_data = seq_req.wr_data;
		end else begin
			ram_wr_en   = in_xfer && !load_full_q;
			ram_wr_addr = load_addr_q;
			ram_wr_data = load_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= gsdc_pkg::GSZ_W'(1);
			day_count_q <= gsdc_pkg::GEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gsdc_pkg::REG_GRID_SIZE: grid_size_q <= cfg_data[gsdc_pkg::GSZ_W-1:0];
				gsdc_pkg::REG_DAY_COUNT: day_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_row_q  <= '0;
			load_col_q  <= '0;
			load_addr_q <= '0;
			load_full_q <= 1'b0;
		end else if (in_xfer) begin
			if (last_cell) begin
				load_row_q  <= '0;
				load_col_q  <= '0;
				load_addr_q <= '0;
				load_full_q <= 1'b0;
			end else if (!load_full_q) begin
				load_addr_q <= load_addr_q + gsdc_pkg::ADDR_W'(1);
				if (load_last_col) begin
					load_col_q <= '0;
					if (load_last_row) begin
						load_full_q <= 1'b1;
					end else begin
						load_row_q <= load_row_q + gsdc_pkg::SIDE_W'(1);
					end
				end else begin
					load_col_q <= load_col_q + gsdc_pkg::SIDE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			count_q <= seq_count;
		end
	end

	assign out_valid    = out_valid_q;
	assign marked_count = count_q;

	gsdc_ram #(
		.DEPTH (gsdc_pkg::MAX_SIDE * gsdc_pkg::MAX_SIDE),
		.DATA_W(2)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (seq_req.rd_en),
		.rd_addr(seq_req.rd_addr),
		.rd_data(rd_data)
	);

	gsdc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.side   (side),
		.gens   (gens),
		.rd_data(rd_data),
		.req    (seq_req),
		.done   (done),
		.count  (seq_count)
	);

endmodule

// ===== src/gsdc_ram.sv =====
// gsdc_ram: simple dual port synchronous ram, one write and one read port
// read data registered; no package dependency
module gsdc_ram #(
	parameter int DEPTH  = 16384,
	parameter int DATA_W = 2
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/gsdc_seq.sv =====
// gsdc_seq: generation sweep sequencer, marks, commits and counts cells
// through the cell ram; uses gsdc_pkg
module gsdc_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [gsdc_pkg::N_W-1:0]     side,
	input  logic [gsdc_pkg::GEN_W-1:0]   gens,
	input  logic [1:0]                   rd_data,
	output gsdc_pkg::mem_req_t           req,
	output logic                         done,
	output logic [gsdc_pkg::CNT_W-1:0]   count
);

	gsdc_pkg::seq_state_t state_q, state_d;
	logic [gsdc_pkg::SIDE_W-1:0] row_q, row_d, col_q, col_d;
	logic [gsdc_pkg::ADDR_W-1:0] addr_q, addr_d;
	logic [gsdc_pkg::K_W-1:0]    k_q, k_d;
	logic [gsdc_pkg::GEN_W-1:0]  gen_q, gen_d;
	logic                        changed_q, changed_d;
	logic [gsdc_pkg::CNT_W-1:0]  count_q, count_d;

	logic [gsdc_pkg::N_W-1:0]    side_m1, row_p1, col_p1;
	logic                        last_col, last_row;
	logic                        nb_ok;
	logic [gsdc_pkg::ADDR_W-1:0] self_addr, nb_addr, side_a, nxt_addr;
	logic [gsdc_pkg::SIDE_W-1:0] nxt_row, nxt_col;

	assign side_m1  = side - gsdc_pkg::N_W'(1);
	assign row_p1   = {1'b0, row_q} + gsdc_pkg::N_W'(1);
	assign col_p1   = {1'b0, col_q} + gsdc_pkg::N_W'(1);
	assign last_col = ({1'b0, col_q} == side_m1);
	assign last_row = ({1'b0, row_q} == side_m1);
	// row-major linear address, row stride is the side in use
	assign side_a    = gsdc_pkg::ADDR_W'(side);
	assign self_addr = addr_q;
	assign nxt_addr  = addr_q + gsdc_pkg::ADDR_W'(1);
	assign nxt_col  = last_col ? '0 : col_p1[gsdc_pkg::SIDE_W-1:0];
	assign nxt_row  = last_col ? row_p1[gsdc_pkg::SIDE_W-1:0] : row_q;

	always_comb begin
		nb_ok   = 1'b1;
		nb_addr = self_addr;
		unique case (k_q)
			gsdc_pkg::NB_UP: begin
				nb_ok   = (row_q != '0);
				nb_addr = addr_q - side_a;
			end
			gsdc_pkg::NB_DOWN: begin
				nb_ok   = (row_p1 < side);
				nb_addr = addr_q + side_a;
			end
			gsdc_pkg::NB_LEFT: begin
				nb_ok   = (col_q != '0);
				nb_addr = addr_q - gsdc_pkg::ADDR_W'(1);
			end
			gsdc_pkg::NB_RIGHT: begin
				nb_ok   = (col_p1 < side);
				nb_addr = nxt_addr;
			end
			default: begin
				nb_ok   = 1'b1;
				nb_addr = self_addr;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= gsdc_pkg::S_IDLE;
			row_q     <= '0;
			col_q     <= '0;
			addr_q    <= '0;
			k_q       <= '0;
			gen_q     <= '0;
			changed_q <= 1'b0;
			count_q   <= '0;
		end else begin
			state_q   <= state_d;
			row_q     <= row_d;
			col_q     <= col_d;
			addr_q    <= addr_d;
			k_q       <= k_d;
			gen_q     <= gen_d;
			changed_q <= changed_d;
			count_q   <= count_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		row_d     = row_q;
		col_d     = col_q;
		addr_d    = addr_q;
		k_d       = k_q;
		gen_d     = gen_q;
		changed_d = changed_q;
		count_d   = count_q;
		req       = '0;
		done      = 1'b0;
		unique case (state_q)
			gsdc_pkg::S_IDLE: begin
				if (start) begin
					row_d     = '0;
					col_d     = '0;
					addr_d    = '0;
					k_d       = gsdc_pkg::NB_SELF;
					gen_d     = '0;
					changed_d = 1'b0;
					count_d   = '0;
					state_d   = (gens == '0) ? gsdc_pkg::S_C_ISSUE : gsdc_pkg::S_A_ISSUE;
				end
			end
			gsdc_pkg::S_A_ISSUE: begin
				if (nb_ok) begin
					req.rd_en   = 1'b1;
					req.rd_addr = nb_addr;
					state_d     = gsdc_pkg::S_A_WAIT;
				end else if (k_q == gsdc_pkg::NB_RIGHT) begin
					k_d    = gsdc_pkg::NB_SELF;
					row_d  = nxt_row;
					col_d  = nxt_col;
					addr_d = nxt_addr;
					if (last_row && last_col) begin
						row_d   = '0;
						addr_d  = '0;
						state_d = changed_q ? gsdc_pkg::S_B_ISSUE : gsdc_pkg::S_C_ISSUE;
					end
				end else begin
					k_d = k_q + gsdc_pkg::K_W'(1);
				end
			end
			gsdc_pkg::S_A_WAIT: begin
				// only cells marked before this generation act as sources
				if ((k_q == gsdc_pkg::NB_SELF && rd_data != gsdc_pkg::KIND_EMPTY) ||
				    (k_q != gsdc_pkg::NB_SELF && rd_data == gsdc_pkg::KIND_MARKED) ||
				    k_q == gsdc_pkg::NB_RIGHT) begin
					if (k_q != gsdc_pkg::NB_SELF && rd_data == gsdc_pkg::KIND_MARKED) begin
						req.wr_en   = 1'b1;
						req.wr_addr = self_addr;
						req.wr_data = gsdc_pkg::KIND_FRESH;
						changed_d   = 1'b1;
					end
					k_d    = gsdc_pkg::NB_SELF;
					row_d  = nxt_row;
					col_d  = nxt_col;
					addr_d = nxt_addr;
					state_d = gsdc_pkg::S_A_ISSUE;
					if (last_row && last_col) begin
						row_d  = '0;
						addr_d = '0;
						if (changed_d) begin
							state_d = gsdc_pkg::S_B_ISSUE;
						end else begin
							state_d = gsdc_pkg::S_C_ISSUE;
						end
					end
				end else begin
					k_d     = k_q + gsdc_pkg::K_W'(1);
					state_d = gsdc_pkg::S_A_ISSUE;
				end
			end
			gsdc_pkg::S_B_ISSUE: begin
				req.rd_en   = 1'b1;
				req.rd_addr = self_addr;
				state_d     = gsdc_pkg::S_B_WAIT;
			end
			gsdc_pkg::S_B_WAIT: begin
				if (rd_data == gsdc_pkg::KIND_FRESH) begin
					req.wr_en   = 1'b1;
					req.wr_addr = self_addr;
					req.wr_data = gsdc_pkg::KIND_MARKED;
				end
				row_d   = nxt_row;
				col_d   = nxt_col;
				addr_d  = nxt_addr;
				state_d = gsdc_pkg::S_B_ISSUE;
				if (last_row && last_col) begin
					row_d     = '0;
					addr_d    = '0;
					gen_d     = gen_q + gsdc_pkg::GEN_W'(1);
					changed_d = 1'b0;
					state_d   = (gen_d == gens) ? gsdc_pkg::S_C_ISSUE : gsdc_pkg::S_A_ISSUE;
				end
			end
			gsdc_pkg::S_C_ISSUE: begin
				req.rd_en   = 1'b1;
				req.rd_addr = self_addr;
				state_d     = gsdc_pkg::S_C_WAIT;
			end
			gsdc_pkg::S_C_WAIT: begin
				if (rd_data == gsdc_pkg::KIND_MARKED) begin
					count_d = count_q + gsdc_pkg::CNT_W'(1);
				end
				row_d   = nxt_row;
				col_d   = nxt_col;
				addr_d  = nxt_addr;
				state_d = gsdc_pkg::S_C_ISSUE;
				if (last_row && last_col) begin
					row_d   = '0;
					addr_d  = '0;
					state_d = gsdc_pkg::S_DONE;
				end
			end
			gsdc_pkg::S_DONE: begin
				done    = 1'b1;
				state_d = gsdc_pkg::S_IDLE;
			end
			default: begin
				state_d = gsdc_pkg::S_IDLE;
			end
		endcase
	end

	assign count = count_q;

endmodule
